// ===== hw/rtl/temporal_iir_bandpass_amplifier_unit_macros.svh =====
// Assertion helpers for the files that carry checks; only the top-level file includes them.
`ifndef TEMPORAL_IIR_BANDPASS_AMPLIFIER_UNIT_MACROS_SVH
`define TEMPORAL_IIR_BANDPASS_AMPLIFIER_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TIBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define TIBA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `TIBA_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/tiba_pkg.sv =====
package tiba_pkg;

    // Frame geometry.
    localparam int C_FRAME_PIXELS = 16384;
    localparam int C_POS_W        = $clog2(C_FRAME_PIXELS);
    localparam logic [C_POS_W-1:0] C_POS_LAST = C_POS_W'(C_FRAME_PIXELS - 1);

    // Field widths.
    localparam int C_PIX_W   = 24;
    localparam int C_COEF_W  = 16;
    localparam int C_CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [C_CFG_IDX_W-1:0] C_REG_ALPHA_FAST = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_ALPHA_SLOW = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_GAIN       = 2'd2;

    // Reset values of the registers.
    localparam logic [C_COEF_W-1:0] C_ALPHA_FAST_RST = 16'd6554;
    localparam logic [C_COEF_W-1:0] C_ALPHA_SLOW_RST = 16'd655;
    localparam logic [C_COEF_W-1:0] C_GAIN_RST       = 16'd2560;

    // 1.0 in Q0.16, and the saturation limits of the Q16.8 result.
    localparam logic [C_COEF_W:0] C_ALPHA_ONE = 17'h10000;
    localparam logic signed [C_PIX_W-1:0] C_AMP_MAX = 24'sh7FFFFF;
    localparam logic signed [C_PIX_W-1:0] C_AMP_MIN = 24'sh800000;

    // Depth of the queue between front and back.
    localparam int C_Q_DEPTH = 4;
    localparam int C_Q_PTR_W = $clog2(C_Q_DEPTH);

    typedef struct packed {
        logic [C_PIX_W-1:0] pixel;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic signed [C_PIX_W-1:0] amplified;
        logic                      frame_end_out;
    } t_out_item;

    typedef struct packed {
        logic [C_COEF_W-1:0] alpha_fast;
        logic [C_COEF_W-1:0] alpha_slow;
        logic [C_COEF_W-1:0] gain;
    } t_cfg;

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        logic [C_PIX_W-1:0] pixel;
        logic               frame_end;
        logic [C_POS_W-1:0] pos;
        logic               first;
    } t_job;

    // Handshake between the queue and the back.
    typedef struct packed {
        logic valid;
        t_job head;
    } t_q_head;

endpackage

// ===== hw/rtl/tiba_ram.sv =====
module tiba_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same address is written.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tiba_front.sv =====
module tiba_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tiba_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output tiba_pkg::t_job    o_job
);
    import tiba_pkg::*;

    logic               r_first_frame;
    logic [C_POS_W-1:0] r_pos;
    logic               n_first_frame;
    logic [C_POS_W-1:0] n_pos;
    logic               w_accept;

    assign w_accept = i_valid && !i_full;

    always_comb begin
        n_first_frame = r_first_frame;
        n_pos         = r_pos;
        if (w_accept) begin
            if (i_item.frame_end) begin
                n_pos         = '0;
                n_first_frame = 1'b0;
            end else if (r_pos == C_POS_LAST) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_frame <= 1'b1;
            r_pos         <= '0;
        end else begin
            r_first_frame <= n_first_frame;
            r_pos         <= n_pos;
        end
    end

    assign o_push          = w_accept;
    assign o_job.pixel     = i_item.pixel;
    assign o_job.frame_end = i_item.frame_end;
    assign o_job.pos       = r_pos;
    assign o_job.first     = r_first_frame;

endmodule

// ===== hw/rtl/tiba_queue.sv =====
module tiba_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tiba_pkg::t_job    i_job,
    output logic              o_full,
    input  logic              i_pop,
    output tiba_pkg::t_q_head o_head
);
    import tiba_pkg::*;

    t_job                 r_mem [C_Q_DEPTH];
    logic [C_Q_PTR_W-1:0] r_wr_ptr;
    logic [C_Q_PTR_W-1:0] r_rd_ptr;
    logic [C_Q_PTR_W:0]   r_count;
    logic                 w_do_pop;

    assign o_full   = (r_count == (C_Q_PTR_W + 1)'(C_Q_DEPTH));
    assign w_do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.head  = r_mem[r_rd_ptr];

endmodule

// ===== hw/rtl/tiba_back.sv =====
module tiba_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tiba_pkg::t_cfg      i_cfg,
    input  tiba_pkg::t_q_head   i_head,
    output logic                o_pop,
    output logic                o_valid,
    output tiba_pkg::t_out_item o_item,
    input  logic                i_stall
);
    import tiba_pkg::*;

    logic w_adv;
    logic w_hazard;

    // Stage 1: stored values arrive from the memories.
    logic               r_s1_v;
    t_job               r_s1;
    logic [C_PIX_W-1:0] w_fast_prev;
    logic [C_PIX_W-1:0] w_slow_prev;
    logic [C_COEF_W:0]  w_coef_fast;
    logic [C_COEF_W:0]  w_coef_slow;

    // Stage 2: partial products of both low-pass filters.
    logic               r_s2_v;
    logic [C_POS_W-1:0] r_s2_pos;
    logic               r_s2_first;
    logic [C_PIX_W-1:0] r_s2_pixel;
    logic               r_s2_fe;
    logic [40:0]        r_s2_fast_old;
    logic [39:0]        r_s2_fast_in;
    logic [40:0]        r_s2_slow_old;
    logic [39:0]        r_s2_slow_in;
    logic [41:0]        w_fast_sum;
    logic [41:0]        w_slow_sum;
    logic [C_PIX_W-1:0] w_fast_new;
    logic [C_PIX_W-1:0] w_slow_new;

    // Stage 3: band-passed difference.
    logic               r_s3_v;
    logic               r_s3_fe;
    logic signed [24:0] r_s3_diff;

    // Stage 4: amplified product.
    logic               r_s4_v;
    logic               r_s4_fe;
    logic signed [41:0] r_s4_prod;
    logic signed [42:0] w_round;
    logic signed [26:0] w_quot;
    logic signed [C_PIX_W-1:0] w_sat;

    logic      r_out_valid;
    t_out_item r_out_item;

    // The whole pipe moves together whenever the output register can take a value.
    assign w_adv = !r_out_valid || !i_stall;

    // A pixel whose entry is still being updated by an item ahead of it waits.
    assign w_hazard = (r_s1_v && (r_s1.pos == i_head.head.pos))
                   || (r_s2_v && (r_s2_pos == i_head.head.pos));
    assign o_pop = w_adv && i_head.valid && !w_hazard;

    tiba_ram #(.WIDTH(C_PIX_W), .DEPTH(C_FRAME_PIXELS)) u_fast_ram (
        .i_clk   (i_clk),
        .i_we    (w_adv && r_s2_v),
        .i_waddr (r_s2_pos),
        .i_wdata (w_fast_new),
        .i_re    (w_adv),
        .i_raddr (i_head.head.pos),
        .o_rdata (w_fast_prev)
    );

    tiba_ram #(.WIDTH(C_PIX_W), .DEPTH(C_FRAME_PIXELS)) u_slow_ram (
        .i_clk   (i_clk),
        .i_we    (w_adv && r_s2_v),
        .i_waddr (r_s2_pos),
        .i_wdata (w_slow_new),
        .i_re    (w_adv),
        .i_raddr (i_head.head.pos),
        .o_rdata (w_slow_prev)
    );

    assign w_coef_fast = C_ALPHA_ONE - {1'b0, i_cfg.alpha_fast};
    assign w_coef_slow = C_ALPHA_ONE - {1'b0, i_cfg.alpha_slow};

    assign w_fast_sum = {1'b0, r_s2_fast_old} + {2'b00, r_s2_fast_in} + 42'd32768;
    assign w_slow_sum = {1'b0, r_s2_slow_old} + {2'b00, r_s2_slow_in} + 42'd32768;
    assign w_fast_new = r_s2_first ? r_s2_pixel : w_fast_sum[39:16];
    assign w_slow_new = r_s2_first ? r_s2_pixel : w_slow_sum[39:16];

    // Round half up by floor division, then clamp to the signed result range.
    always_comb begin
        w_round = {r_s4_prod[41], r_s4_prod} + 43'sd32768;
        w_quot  = $signed(w_round[42:16]);
        if (w_quot > C_AMP_MAX) begin
            w_sat = C_AMP_MAX;
        end else if (w_quot < C_AMP_MIN) begin
            w_sat = C_AMP_MIN;
        end else begin
            w_sat = w_quot[C_PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= i_head.head;

            r_s2_pos      <= r_s1.pos;
            r_s2_first    <= r_s1.first;
            r_s2_pixel    <= r_s1.pixel;
            r_s2_fe       <= r_s1.frame_end;
            r_s2_fast_old <= 41'(w_fast_prev) * 41'(w_coef_fast);
            r_s2_fast_in  <= 40'(r_s1.pixel) * 40'(i_cfg.alpha_fast);
            r_s2_slow_old <= 41'(w_slow_prev) * 41'(w_coef_slow);
            r_s2_slow_in  <= 40'(r_s1.pixel) * 40'(i_cfg.alpha_slow);

            r_s3_fe   <= r_s2_fe;
            r_s3_diff <= $signed({1'b0, w_fast_new}) - $signed({1'b0, w_slow_new});

            r_s4_fe   <= r_s3_fe;
            r_s4_prod <= 42'(r_s3_diff) * 42'($signed({1'b0, i_cfg.gain}));

            r_out_item.amplified     <= w_sat;
            r_out_item.frame_end_out <= r_s4_fe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_v      <= o_pop;
            r_s2_v      <= r_s1_v;
            r_s3_v      <= r_s2_v;
            r_s4_v      <= r_s3_v;
            r_out_valid <= r_s4_v;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

// ===== hw/rtl/temporal_iir_bandpass_amplifier_unit.sv =====
// Temporal band-pass amplifier for one reduced video channel. Pixels enter in raster
// order, one item per clock while o_stall is low, the last pixel of each frame marked by
// frame_end; every pixel gives exactly one result item, in order. For each pixel position
// the block keeps a fast and a slow first-order low-pass value (Q8.16) in two on-chip
// memories of 16384 entries and returns gain times their difference as a rounded,
// saturated Q16.8 value. All results of the first frame after reset are zero, since that
// frame only loads the memories. The block sustains one item per clock while the receiver
// does not stall and no pixel waits; the limit is the single read and write port of each
// filter memory, one access of each kind per cycle. When a frame has fewer than three
// positions, a pixel waits until an earlier pixel of its position has left stage 2. A
// four-entry queue between the input side and the filter pipeline absorbs output stalls,
// so input stall rises only once that queue is full. The user must write the configuration
// registers (alpha_fast at index 0, alpha_slow at 1, gain at 2) only while no item is in
// flight; the block itself does not enforce this. A write to any other index is ignored.
`include "temporal_iir_bandpass_amplifier_unit_macros.svh"

module temporal_iir_bandpass_amplifier_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input pixel channel.
    input  logic                             i_valid,
    input  tiba_pkg::t_in_item               i_item,
    output logic                             o_stall,
    // Result channel.
    output logic                             o_valid,
    output tiba_pkg::t_out_item              o_item,
    input  logic                             i_stall,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [tiba_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tiba_pkg::C_COEF_W-1:0]    i_cfg_data
);
    import tiba_pkg::*;

    t_cfg    r_cfg;
    logic    w_push;
    t_job    w_job;
    logic    w_full;
    logic    w_pop;
    t_q_head w_head;
    logic    w_out_held;
    logic    w_cfg_unlisted;

    // Configuration registers. Each register is 16 bits, the width of the data port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha_fast <= C_ALPHA_FAST_RST;
            r_cfg.alpha_slow <= C_ALPHA_SLOW_RST;
            r_cfg.gain       <= C_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_ALPHA_FAST: r_cfg.alpha_fast <= i_cfg_data;
                C_REG_ALPHA_SLOW: r_cfg.alpha_slow <= i_cfg_data;
                C_REG_GAIN:       r_cfg.gain       <= i_cfg_data;
                default:          r_cfg            <= r_cfg;
            endcase
        end
    end

    // The front tags each accepted pixel with its position and first-frame flag.
    tiba_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    // The input side stalls only while the queue is full.
    assign o_stall = w_full;

    tiba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // The back reads both stores, filters, writes them back and amplifies.
    tiba_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

    // A result is held when the receiver stalls it; an unlisted index selects no register.
    assign w_out_held     = o_valid && i_stall;
    assign w_cfg_unlisted = i_cfg_we && (i_cfg_idx != C_REG_ALPHA_FAST)
                         && (i_cfg_idx != C_REG_ALPHA_SLOW) && (i_cfg_idx != C_REG_GAIN);

    // The back never takes an item from an empty queue.
    `TIBA_ASSERT(a_pop_needs_item, i_clk, i_rst_n, w_pop |-> w_head.valid, "pop from empty queue")

    // While a result is held by the receiver, the pipeline must not take new work.
    `TIBA_ASSERT_NEVER(a_no_pop_held, i_clk, i_rst_n, w_out_held && w_pop, "pop while held")

    // A write to an index outside the register list changes no register.
    `TIBA_ASSERT(a_bad_idx, i_clk, i_rst_n, w_cfg_unlisted |=> $stable(r_cfg), "bad index")

endmodule
